// ----- rtl/core/pwm_capture_frequency_duty_meter_core_defines.svh -----
// Assertion macros used by the capture meter top level.
`ifndef PWM_CAPTURE_FREQUENCY_DUTY_METER_CORE_DEFINES_SVH
`define PWM_CAPTURE_FREQUENCY_DUTY_METER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define PCFDM_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("capture meter assertion failed");

// Next-cycle implication, disabled while reset is low.
`define PCFDM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("capture meter assertion failed");

`endif

// ----- rtl/core/pcfdm_pkg.sv -----
// Shared constants and controller/datapath interface types of the capture meter.
package pcfdm_pkg;

    // Block configuration
    localparam int CHANNELS   = 2;
    localparam int TIMER_BITS = 16;

    localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int TS_W     = 16;               // timestamp port width
    localparam int RES_W    = 16;               // width of result fields
    localparam int TICK_W   = 27;               // tick_rate register width
    localparam int PER_W    = TIMER_BITS + 1;   // high + low period width
    localparam int DUTY_BITS = 16;              // Q0.16 fraction bits

    localparam int DIV_CNT_W = $clog2(TICK_W + 1);

    localparam logic [TICK_W-1:0] TICK_RATE_RESET = 27'd1000000;
    localparam logic [RES_W-1:0]  SAT16           = 16'hFFFF;

    // Per-channel phase codes
    localparam logic [1:0] PH_RISE = 2'd0;
    localparam logic [1:0] PH_FALL = 2'd1;
    localparam logic [1:0] PH_LOW  = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic eval;
        logic start_freq;
        logic store_freq;
        logic start_duty;
        logic store_duty;
        logic emit;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic need_div;
        logic full_duty;
        logic div_done;
        logic out_free;
    } t_sts;

endpackage

// ----- rtl/core/pcfdm_div.sv -----
// Shared restoring divider, one quotient bit per cycle.
module pcfdm_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [pcfdm_pkg::PER_W-1:0]       i_init_rem,
    input  logic [pcfdm_pkg::TICK_W-1:0]      i_dividend,
    input  logic [pcfdm_pkg::PER_W-1:0]       i_divisor,
    input  logic [pcfdm_pkg::DIV_CNT_W-1:0]   i_steps,
    output logic                              o_done,
    output logic [pcfdm_pkg::TICK_W-1:0]      o_quotient
);
    import pcfdm_pkg::*;

    logic [PER_W-1:0]     r_rem;
    logic [TICK_W-1:0]    r_dvd;
    logic [TICK_W-1:0]    r_quo;
    logic [PER_W-1:0]     r_dvs;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;

    logic [PER_W:0]       trial;
    logic [PER_W:0]       diff;
    logic                 fits;
    logic                 last_step;

    // One trial subtraction per cycle
    assign trial     = {r_rem, r_dvd[TICK_W-1]};
    assign diff      = trial - {1'b0, r_dvs};
    assign fits      = (trial >= {1'b0, r_dvs});
    assign last_step = r_busy && (r_cnt == DIV_CNT_W'(1));

    // Control: busy flag and done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= !i_start && last_step;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (last_step) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_init_rem;
            r_dvd <= i_dividend;
            r_quo <= '0;
            r_dvs <= i_divisor;
            r_cnt <= i_steps;
        end else if (r_busy) begin
            r_rem <= fits ? diff[PER_W-1:0] : trial[PER_W-1:0];
            r_dvd <= {r_dvd[TICK_W-2:0], 1'b0};
            r_quo <= {r_quo[TICK_W-2:0], fits};
            r_cnt <= r_cnt - DIV_CNT_W'(1);
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ----- rtl/core/pcfdm_dp.sv -----
// Datapath: channel state, width arithmetic, divider, result and output registers.
module pcfdm_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_capture,
    input  logic                          i_channel,
    input  logic [pcfdm_pkg::TS_W-1:0]    i_timestamp,
    input  logic                          i_cfg_we,
    input  logic [pcfdm_pkg::TICK_W-1:0]  i_cfg_wdata,
    input  logic                          i_out_ready,
    input  pcfdm_pkg::t_cmd               i_cmd,
    output pcfdm_pkg::t_sts               o_sts,
    output logic                          o_out_valid,
    output logic                          o_out_channel,
    output logic                          o_arm_falling,
    output logic                          o_measurement_valid,
    output logic [pcfdm_pkg::RES_W-1:0]   o_high_ticks,
    output logic [pcfdm_pkg::RES_W-1:0]   o_low_ticks,
    output logic [pcfdm_pkg::RES_W-1:0]   o_frequency_hz,
    output logic [pcfdm_pkg::RES_W-1:0]   o_duty_fraction,
    output logic                          o_period_zero
);
    import pcfdm_pkg::*;

    function automatic logic [RES_W-1:0] sat16(input logic [TICK_W-1:0] v);
        logic [RES_W-1:0] res;
        res = (v > TICK_W'(SAT16)) ? SAT16 : v[RES_W-1:0];
        return res;
    endfunction

    // Configuration and captured item
    logic [TICK_W-1:0]     r_tick_rate;
    logic                  r_ch;
    logic [TS_W-1:0]       r_ts;

    // Per-channel state
    logic [1:0]            r_phase [CHANNELS];
    logic [TIMER_BITS-1:0] r_start [CHANNELS];
    logic [TIMER_BITS-1:0] r_hw    [CHANNELS];

    // Result staging
    logic                  r_res_arm;
    logic                  r_res_mv;
    logic                  r_res_pz;
    logic [TIMER_BITS-1:0] r_hi;
    logic [TIMER_BITS-1:0] r_lo;
    logic [PER_W-1:0]      r_period;
    logic [RES_W-1:0]      r_res_freq;
    logic [RES_W-1:0]      r_res_duty;

    // Output register
    logic                  r_out_valid;
    logic                  r_out_ch;
    logic                  r_out_arm;
    logic                  r_out_mv;
    logic                  r_out_pz;
    logic [RES_W-1:0]      r_out_hi;
    logic [RES_W-1:0]      r_out_lo;
    logic [RES_W-1:0]      r_out_freq;
    logic [RES_W-1:0]      r_out_duty;

    logic [CH_IDX_W-1:0]   ch_idx;
    logic                  ch_ok;
    logic [TIMER_BITS-1:0] t_now;
    logic [1:0]            cur_phase;
    logic [TIMER_BITS-1:0] cur_start;
    logic [TIMER_BITS-1:0] cur_hw;
    logic [TIMER_BITS-1:0] width;
    logic [PER_W-1:0]      period_c;
    logic                  is_fall;
    logic                  is_meas;

    logic                  div_start;
    logic [PER_W-1:0]      div_init;
    logic [TICK_W-1:0]     div_dividend;
    logic [DIV_CNT_W-1:0]  div_steps;
    logic                  div_done;
    logic [TICK_W-1:0]     div_quo;

    // Channel lookup and width arithmetic (modulo timer width)
    assign ch_idx    = CH_IDX_W'(r_ch);
    assign ch_ok     = (32'(r_ch) < CHANNELS);
    assign t_now     = TIMER_BITS'(r_ts);
    assign cur_phase = r_phase[ch_idx];
    assign cur_start = r_start[ch_idx];
    assign cur_hw    = r_hw[ch_idx];
    assign width     = t_now - cur_start;
    assign period_c  = PER_W'(cur_hw) + PER_W'(width);
    assign is_fall   = ch_ok && (cur_phase == PH_FALL);
    assign is_meas   = ch_ok && (cur_phase == PH_LOW);

    // Control state: config, channel phases and stored times, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_rate <= TICK_RATE_RESET;
            r_out_valid <= 1'b0;
            for (int k = 0; k < CHANNELS; k++) begin
                r_phase[k] <= PH_RISE;
                r_start[k] <= '0;
                r_hw[k]    <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_tick_rate <= i_cfg_wdata;
            end
            if (i_cmd.eval && ch_ok) begin
                if (is_fall) begin
                    r_hw[ch_idx]    <= width;
                    r_start[ch_idx] <= t_now;
                    r_phase[ch_idx] <= PH_LOW;
                end else if (is_meas) begin
                    r_phase[ch_idx] <= PH_RISE;
                end else begin
                    // rising edge; the unused phase code lands here too
                    r_start[ch_idx] <= t_now;
                    r_phase[ch_idx] <= PH_FALL;
                end
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Captured item
    always_ff @(posedge i_clk) begin
        if (i_capture) begin
            r_ch <= i_channel;
            r_ts <= i_timestamp;
        end
    end

    // Result staging
    always_ff @(posedge i_clk) begin
        if (i_cmd.eval) begin
            r_res_arm  <= ch_ok && !is_fall && !is_meas;
            r_res_mv   <= is_meas;
            r_res_pz   <= is_meas && (period_c == '0);
            r_hi       <= is_meas ? cur_hw : '0;
            r_lo       <= is_meas ? width : '0;
            r_period   <= period_c;
            r_res_freq <= '0;
            r_res_duty <= '0;
        end
        if (i_cmd.store_freq) begin
            r_res_freq <= sat16(div_quo);
            // no low time: duty is a full period
            if (r_lo == '0) begin
                r_res_duty <= SAT16;
            end
        end
        if (i_cmd.store_duty) begin
            r_res_duty <= sat16(div_quo);
        end
    end

    // Output register payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_ch   <= r_ch;
            r_out_arm  <= r_res_arm;
            r_out_mv   <= r_res_mv;
            r_out_pz   <= r_res_pz;
            r_out_hi   <= RES_W'(r_hi);
            r_out_lo   <= RES_W'(r_lo);
            r_out_freq <= r_res_freq;
            r_out_duty <= r_res_duty;
        end
    end

    // Divider operands: tick_rate / period, then (high << 16) / period
    // with high < period, so the remainder starts at high.
    assign div_start    = i_cmd.start_freq || i_cmd.start_duty;
    assign div_init     = i_cmd.start_duty ? PER_W'(r_hi) : '0;
    assign div_dividend = i_cmd.start_duty ? '0 : r_tick_rate;
    assign div_steps    = i_cmd.start_duty ? DIV_CNT_W'(DUTY_BITS) : DIV_CNT_W'(TICK_W);

    pcfdm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_init_rem (div_init),
        .i_dividend (div_dividend),
        .i_divisor  (r_period),
        .i_steps    (div_steps),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // Status back to the controller
    assign o_sts.need_div  = is_meas && (period_c != '0);
    assign o_sts.full_duty = (r_lo == '0);
    assign o_sts.div_done  = div_done;
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid         = r_out_valid;
    assign o_out_channel       = r_out_ch;
    assign o_arm_falling       = r_out_arm;
    assign o_measurement_valid = r_out_mv;
    assign o_high_ticks        = r_out_hi;
    assign o_low_ticks         = r_out_lo;
    assign o_frequency_hz      = r_out_freq;
    assign o_duty_fraction     = r_out_duty;
    assign o_period_zero       = r_out_pz;

endmodule

// ----- rtl/core/pcfdm_ctrl.sv -----
// Controller: sequences evaluation, the two divisions and the result hand-off.
module pcfdm_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  pcfdm_pkg::t_sts  i_sts,
    output logic             o_in_ready,
    output logic             o_capture,
    output pcfdm_pkg::t_cmd  o_cmd
);
    import pcfdm_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_EVAL   = 6'b000010,
        S_FSTART = 6'b000100,
        S_FWAIT  = 6'b001000,
        S_DWAIT  = 6'b010000,
        S_EMIT   = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        o_capture  = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_capture = 1'b1;
                    n_state   = S_EVAL;
                end
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state    = i_sts.need_div ? S_FSTART : S_EMIT;
            end
            S_FSTART: begin
                o_cmd.start_freq = 1'b1;
                n_state          = S_FWAIT;
            end
            S_FWAIT: begin
                if (i_sts.div_done) begin
                    o_cmd.store_freq = 1'b1;
                    if (i_sts.full_duty) begin
                        n_state = S_EMIT;
                    end else begin
                        o_cmd.start_duty = 1'b1;
                        n_state          = S_DWAIT;
                    end
                end
            end
            S_DWAIT: begin
                if (i_sts.div_done) begin
                    o_cmd.store_duty = 1'b1;
                    n_state          = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- rtl/core/pwm_capture_frequency_duty_meter_core.sv -----
// Top level of the PWM capture frequency and duty meter.
//
//  channel  direction  handshake                  payload
//  -------  ---------  -------------------------  -----------------------------------------
//  in       to core    i_in_valid / o_in_ready    i_channel, i_timestamp
//  out      from core  o_out_valid / i_out_ready  channel, arm, widths, freq, duty, flags
//  cfg      to core    i_cfg_we                   i_cfg_wdata (tick rate)
//
// An edge that only stores a time is evaluated and then handed to the output register.
// An edge that ends a measurement also runs the shared one-bit-per-cycle divider, for
// 27 quotient bits of frequency and then 16 of duty. With a zero low width the duty
// division is skipped; a zero period skips both.
// One item is in work at a time; the output register lets the next item in while a
// result waits. A stalled output holds the controller in its hand-off state.
// Synchronous active-low reset clears channel phases and stored times and sets the tick rate to 1000000.
module pwm_capture_frequency_duty_meter_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_channel,
    input  logic [pcfdm_pkg::TS_W-1:0]    i_timestamp,
    input  logic                          i_cfg_we,
    input  logic [pcfdm_pkg::TICK_W-1:0]  i_cfg_wdata,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_out_channel,
    output logic                          o_arm_falling,
    output logic                          o_measurement_valid,
    output logic [pcfdm_pkg::RES_W-1:0]   o_high_ticks,
    output logic [pcfdm_pkg::RES_W-1:0]   o_low_ticks,
    output logic [pcfdm_pkg::RES_W-1:0]   o_frequency_hz,
    output logic [pcfdm_pkg::RES_W-1:0]   o_duty_fraction,
    output logic                          o_period_zero
);
    import pcfdm_pkg::*;

    `include "pwm_capture_frequency_duty_meter_core_defines.svh"

    t_cmd cmd;
    t_sts sts;
    logic capture;

    pcfdm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_in_ready (o_in_ready),
        .o_capture  (capture),
        .o_cmd      (cmd)
    );

    pcfdm_dp u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_capture           (capture),
        .i_channel           (i_channel),
        .i_timestamp         (i_timestamp),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_wdata         (i_cfg_wdata),
        .i_out_ready         (i_out_ready),
        .i_cmd               (cmd),
        .o_sts               (sts),
        .o_out_valid         (o_out_valid),
        .o_out_channel       (o_out_channel),
        .o_arm_falling       (o_arm_falling),
        .o_measurement_valid (o_measurement_valid),
        .o_high_ticks        (o_high_ticks),
        .o_low_ticks         (o_low_ticks),
        .o_frequency_hz      (o_frequency_hz),
        .o_duty_fraction     (o_duty_fraction),
        .o_period_zero       (o_period_zero)
    );

    // An accepted item keeps the input closed in the next cycle
    `PCFDM_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)

    // A new result appears only after an item was in work
    `PCFDM_ASSERT_NOW(a_result_from_item, i_clk, i_rst_n, $rose(o_out_valid), $past(!o_in_ready))

    // Zero period forces both quotients to zero in a valid measurement
    `PCFDM_ASSERT_NOW(a_zero_period, i_clk, i_rst_n, o_out_valid && o_period_zero, o_measurement_valid && (o_frequency_hz == '0) && (o_duty_fraction == '0))

    // Edges that end no measurement carry no widths or quotients
    `PCFDM_ASSERT_NOW(a_no_meas_zero, i_clk, i_rst_n, o_out_valid && !o_measurement_valid, (o_high_ticks == '0) && (o_low_ticks == '0) && (o_frequency_hz == '0) && !o_period_zero)

endmodule
